### rtl/core/sphv_pkg.sv
// ----------------------------------------------------------------------------
// sphv_pkg: shared types, constants and arithmetic helpers
// Word layouts, register indexes and the Q1.30 rounding multiply used by the
// UV sphere vertex pipeline.
// ----------------------------------------------------------------------------
package sphv_pkg;

    localparam int MAX_SEGMENTS_DEF = 64;
    localparam int ANGLE_BITS_DEF   = 16;
    localparam int MIN_SEGMENTS     = 4;

    localparam int RING_IN_W = 6;
    localparam int SEG_IN_W  = 7;
    localparam int POS_W     = 32;
    localparam int NRM_W     = 16;
    localparam int TEX_W     = 17;
    localparam int TEX_FRAC  = 16;
    localparam int RAD_W     = 31;

    // Q1.30 magnitudes
    localparam int Q_W    = 31;
    localparam int Q_FRAC = 30;
    localparam logic [Q_W-1:0] Q_ONE      = Q_W'(64'd1 << Q_FRAC);
    localparam logic [29:0]    QUARTER_PI = 30'd843314857;

    localparam logic [TEX_W-1:0] TEX_ONE = TEX_W'(64'd1 << TEX_FRAC);

    localparam int HORNER_LAT = 3;
    localparam int SIN_CELLS  = 4;
    localparam int COS_CELLS  = 5;
    localparam int TRIG_LAT   = 2 + COS_CELLS * HORNER_LAT + 1;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_SEGMENT_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Z      = 3'd4;

    localparam logic [SEG_IN_W-1:0] RST_SEGMENT_COUNT = 7'd12;
    localparam logic [RAD_W-1:0]    RST_RADIUS        = 31'd65536;

    typedef struct packed {
        logic [RING_IN_W-1:0] ring;
        logic [SEG_IN_W-1:0]  segment;
    } t_in_word;

    typedef struct packed {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
        logic signed [NRM_W-1:0] normal_x;
        logic signed [NRM_W-1:0] normal_y;
        logic signed [NRM_W-1:0] normal_z;
        logic [TEX_W-1:0]        tex_u;
        logic [TEX_W-1:0]        tex_v;
    } t_out_word;

    typedef struct packed {
        logic [Q_W-1:0] sin_mag;
        logic           sin_neg;
        logic [Q_W-1:0] cos_mag;
        logic           cos_neg;
    } t_trig_out;

    // Q1.30 product rounded half up
    function automatic logic [Q_W-1:0] mulq(input logic [Q_W-1:0] a,
                                            input logic [Q_W-1:0] b);
        logic [2*Q_W-1:0] p;
        p = (2*Q_W)'(a) * (2*Q_W)'(b) + (2*Q_W)'(64'd1 << (Q_FRAC - 1));
        return p[Q_FRAC +: Q_W];
    endfunction

endpackage

### rtl/core/sphv_div.sv
// ----------------------------------------------------------------------------
// sphv_div: pipelined restoring divider
// A row of cells, one quotient bit each, most significant first. Each cell
// compares against the shifted divisor and hands remainder and quotient on.
// ----------------------------------------------------------------------------
module sphv_div #(
    parameter int NW = 24,
    parameter int DW = 7,
    parameter int QB = 17
) (
    input  logic          i_clk,
    input  logic [NW-1:0] i_dividend,
    input  logic [DW-1:0] i_divisor,
    output logic [QB-1:0] o_quot
);
    logic [NW-1:0] r_rem [QB];
    logic [DW-1:0] r_dvs [QB];
    logic [QB-1:0] r_quo [QB];

    for (genvar gi = 0; gi < QB; gi++) begin : g_cell
        localparam int B = QB - 1 - gi;
        logic [NW-1:0] w_rem_in;
        logic [NW-1:0] w_sub;
        logic [DW-1:0] w_dvs_in;
        logic [QB-1:0] w_quo_in;
        logic          w_ge;

        if (gi == 0) begin : g_head
            assign w_rem_in = i_dividend;
            assign w_dvs_in = i_divisor;
            assign w_quo_in = '0;
        end else begin : g_link
            assign w_rem_in = r_rem[gi-1];
            assign w_dvs_in = r_dvs[gi-1];
            assign w_quo_in = r_quo[gi-1];
        end

        assign w_sub = NW'(w_dvs_in) << B;
        assign w_ge  = (w_rem_in >= w_sub);

        always_ff @(posedge i_clk) begin
            r_rem[gi] <= w_ge ? (w_rem_in - w_sub) : w_rem_in;
            r_dvs[gi] <= w_dvs_in;
            r_quo[gi] <= w_ge ? (w_quo_in | (QB'(1) << B)) : w_quo_in;
        end
    end

    assign o_quot = r_quo[QB-1];
endmodule

### rtl/core/sphv_horner_cell.sv
// ----------------------------------------------------------------------------
// sphv_horner_cell: one Taylor series step
// t_out = 1 - round(round(x2 * t_in) / K), three register stages. The
// constant divide is a reciprocal multiply with one correction step.
// ----------------------------------------------------------------------------
module sphv_horner_cell #(
    parameter int K = 6
) (
    input  logic                     i_clk,
    input  logic [sphv_pkg::Q_W-1:0] i_x2,
    input  logic [sphv_pkg::Q_W-1:0] i_t,
    output logic [sphv_pkg::Q_W-1:0] o_x2,
    output logic [sphv_pkg::Q_W-1:0] o_t
);
    import sphv_pkg::*;

    localparam logic [31:0]    RECIP  = 32'((64'd1 << 32) / K);
    localparam logic [Q_W-1:0] HALF_K = Q_W'(K / 2);
    localparam logic [Q_W-1:0] K_Q    = Q_W'(K);

    logic [Q_W-1:0]    r_n1, r_x2_1;
    logic [Q_W-1:0]    r_n2, r_q2, r_x2_2;
    logic [Q_W-1:0]    r_t3, r_x2_3;
    logic [Q_W+31:0]   w_prod;
    logic [Q_W-1:0]    w_rem;
    logic [Q_W-1:0]    w_q;

    assign w_prod = (Q_W+32)'(r_n1) * (Q_W+32)'(RECIP);
    // estimate is the quotient or one below it
    assign w_rem  = r_n2 - r_q2 * K_Q;
    assign w_q    = (w_rem >= K_Q) ? (r_q2 + 1'b1) : r_q2;

    always_ff @(posedge i_clk) begin
        r_n1   <= mulq(i_x2, i_t) + HALF_K;
        r_x2_1 <= i_x2;
        r_n2   <= r_n1;
        r_q2   <= w_prod[32 +: Q_W];
        r_x2_2 <= r_x2_1;
        r_t3   <= Q_ONE - w_q;
        r_x2_3 <= r_x2_2;
    end

    assign o_t  = r_t3;
    assign o_x2 = r_x2_3;
endmodule

### rtl/core/sphv_trig.sv
// ----------------------------------------------------------------------------
// sphv_trig: pipelined sine and cosine of a phase
// Octant reduction, then two rows of Horner cells (sine and cosine) and an
// octant fold into signed magnitudes.
// ----------------------------------------------------------------------------
module sphv_trig #(
    parameter int ANGLE_BITS = sphv_pkg::ANGLE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic [ANGLE_BITS-1:0] i_phase,
    output sphv_pkg::t_trig_out   o_trig
);
    import sphv_pkg::*;

    localparam int OCT_SH  = ANGLE_BITS - 3;
    localparam int XP_W    = OCT_SH + Q_W;
    localparam logic [OCT_SH:0] OCT_LEN = (OCT_SH+1)'(1) << OCT_SH;
    localparam int SIN_DLY = SIN_CELLS * HORNER_LAT;
    localparam int COS_DLY = COS_CELLS * HORNER_LAT;
    localparam int PAD     = COS_DLY - SIN_DLY;
    localparam int SIN_K [SIN_CELLS] = '{72, 42, 20, 6};
    localparam int COS_K [COS_CELLS] = '{90, 56, 30, 12, 2};

    logic [2:0]        w_oct;
    logic [OCT_SH-1:0] w_rem;
    logic [OCT_SH:0]   w_r;
    logic [XP_W-1:0]   w_xp;
    logic              w_swap;

    logic [Q_W-1:0] r_x1;
    logic [2:0]     r_oct1;
    logic [Q_W-1:0] r_x2, r_xa;
    logic [2:0]     r_oct2;
    logic [Q_W-1:0] r_xd   [SIN_DLY];
    logic [2:0]     r_octd [COS_DLY];
    logic [Q_W-1:0] r_s    [PAD];
    t_trig_out      r_out;

    logic [Q_W-1:0] w_sin_t  [SIN_CELLS+1];
    logic [Q_W-1:0] w_sin_x2 [SIN_CELLS];
    logic [Q_W-1:0] w_cos_t  [COS_CELLS+1];
    logic [Q_W-1:0] w_cos_x2 [COS_CELLS];

    assign w_oct = i_phase[ANGLE_BITS-1 -: 3];
    assign w_rem = i_phase[OCT_SH-1:0];
    // odd octants run backward
    assign w_r   = w_oct[0] ? (OCT_LEN - {1'b0, w_rem}) : {1'b0, w_rem};
    assign w_xp  = XP_W'(w_r) * XP_W'(QUARTER_PI) + XP_W'(OCT_LEN >> 1);

    always_ff @(posedge i_clk) begin
        r_x1   <= w_xp[OCT_SH +: Q_W];
        r_oct1 <= w_oct;
        r_x2   <= mulq(r_x1, r_x1);
        r_xa   <= r_x1;
        r_oct2 <= r_oct1;
    end

    assign w_sin_t[0]  = Q_ONE;
    assign w_sin_x2[0] = r_x2;
    assign w_cos_t[0]  = Q_ONE;
    assign w_cos_x2[0] = r_x2;

    for (genvar gi = 0; gi < SIN_CELLS; gi++) begin : g_sin
        if (gi < SIN_CELLS - 1) begin : g_mid
            sphv_horner_cell #(.K(SIN_K[gi])) u_cell (
                .i_clk (i_clk),
                .i_x2  (w_sin_x2[gi]),
                .i_t   (w_sin_t[gi]),
                .o_x2  (w_sin_x2[gi+1]),
                .o_t   (w_sin_t[gi+1])
            );
        end else begin : g_last
            sphv_horner_cell #(.K(SIN_K[gi])) u_cell (
                .i_clk (i_clk),
                .i_x2  (w_sin_x2[gi]),
                .i_t   (w_sin_t[gi]),
                .o_x2  (),
                .o_t   (w_sin_t[gi+1])
            );
        end
    end

    for (genvar gi = 0; gi < COS_CELLS; gi++) begin : g_cos
        if (gi < COS_CELLS - 1) begin : g_mid
            sphv_horner_cell #(.K(COS_K[gi])) u_cell (
                .i_clk (i_clk),
                .i_x2  (w_cos_x2[gi]),
                .i_t   (w_cos_t[gi]),
                .o_x2  (w_cos_x2[gi+1]),
                .o_t   (w_cos_t[gi+1])
            );
        end else begin : g_last
            sphv_horner_cell #(.K(COS_K[gi])) u_cell (
                .i_clk (i_clk),
                .i_x2  (w_cos_x2[gi]),
                .i_t   (w_cos_t[gi]),
                .o_x2  (),
                .o_t   (w_cos_t[gi+1])
            );
        end
    end

    always_ff @(posedge i_clk) begin
        r_xd[0]   <= r_xa;
        r_octd[0] <= r_oct2;
        for (int i = 1; i < SIN_DLY; i++) begin
            r_xd[i] <= r_xd[i-1];
        end
        for (int i = 1; i < COS_DLY; i++) begin
            r_octd[i] <= r_octd[i-1];
        end
        // sine is done early, pad it to meet cosine
        r_s[0] <= mulq(r_xd[SIN_DLY-1], w_sin_t[SIN_CELLS]);
        for (int i = 1; i < PAD; i++) begin
            r_s[i] <= r_s[i-1];
        end
    end

    assign w_swap = r_octd[COS_DLY-1][0] ^ r_octd[COS_DLY-1][1];

    always_ff @(posedge i_clk) begin
        r_out.sin_mag <= w_swap ? w_cos_t[COS_CELLS] : r_s[PAD-1];
        r_out.cos_mag <= w_swap ? r_s[PAD-1] : w_cos_t[COS_CELLS];
        r_out.sin_neg <= r_octd[COS_DLY-1][2];
        r_out.cos_neg <= r_octd[COS_DLY-1][2] ^ r_octd[COS_DLY-1][1];
    end

    assign o_trig = r_out;
endmodule

### rtl/core/uv_sphere_vertex_generator_top.sv
// ----------------------------------------------------------------------------
// uv_sphere_vertex_generator_top: UV sphere vertex generator
// Turns a (ring, segment) grid point into position, normal and texcoords.
//
//   channel  | handshake              | word
//   ---------+------------------------+-----------------------------------
//   item in  | start / busy           | i_item   (ring, segment)
//   vertex   | o_valid (strobe)       | o_result (pos, normal, tex)
//   config   | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// One word accepted per cycle while busy is low; each vertex passes through an
// input register, the divider cell rows (QB = max(ANGLE_BITS + 1, 17)), the
// 18-stage sine/cosine unit and the direction, scale and offset registers.
// Synchronous reset clears config to defaults and flushes the pipeline; busy
// is high for the cycle after reset. The vertex strobe lasts one cycle and is
// never held off.
// ----------------------------------------------------------------------------
module uv_sphere_vertex_generator_top #(
    parameter int MAX_SEGMENTS = sphv_pkg::MAX_SEGMENTS_DEF,
    parameter int ANGLE_BITS   = sphv_pkg::ANGLE_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  sphv_pkg::t_in_word                  i_item,
    output logic                                o_valid,
    output sphv_pkg::t_out_word                 o_result,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [sphv_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [sphv_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import sphv_pkg::*;

    localparam int SEG_W   = $clog2(MAX_SEGMENTS + 1);
    localparam int RING_W  = SEG_W - 1;
    localparam int QB      = (ANGLE_BITS + 1 > TEX_W) ? ANGLE_BITS + 1 : TEX_W;
    localparam int NW      = SEG_W + QB;
    localparam int LATENCY = 1 + QB + TRIG_LAT + 3;
    localparam int TEX_DLY = TRIG_LAT + 2;
    localparam logic signed [POS_W+1:0] SUM_MAX = (POS_W+2)'(32'h7fff_ffff);
    localparam logic signed [POS_W+1:0] SUM_MIN = -SUM_MAX - 1;

    function automatic logic [POS_W-1:0] scale(input logic [RAD_W-1:0] rad,
                                               input logic [Q_W-1:0] mag);
        logic [RAD_W+Q_W-1:0] p;
        p = (RAD_W+Q_W)'(rad) * (RAD_W+Q_W)'(mag)
            + (RAD_W+Q_W)'(64'd1 << (Q_FRAC - 1));
        return p[Q_FRAC +: POS_W];
    endfunction

    function automatic logic signed [NRM_W-1:0] to_normal(input logic [Q_W-1:0] mag,
                                                          input logic neg);
        logic [Q_W:0]       rnd;
        logic [NRM_W-1:0]   n;
        rnd = {1'b0, mag} + (Q_W+1)'(64'd1 << 15);
        n   = NRM_W'(rnd >> 16);
        return neg ? $signed(-n) : $signed(n);
    endfunction

    function automatic logic signed [POS_W-1:0] sat_add(input logic signed [POS_W-1:0] c,
                                                        input logic [POS_W-1:0] off,
                                                        input logic neg);
        logic signed [POS_W+1:0] ce, oe, s;
        ce = {{2{c[POS_W-1]}}, c};
        oe = $signed({2'b00, off});
        s  = neg ? (ce - oe) : (ce + oe);
        if (s > SUM_MAX) begin
            s = SUM_MAX;
        end else if (s < SUM_MIN) begin
            s = SUM_MIN;
        end
        return $signed(s[POS_W-1:0]);
    endfunction

    // config registers
    logic [SEG_IN_W-1:0]     r_seg_count;
    logic [RAD_W-1:0]        r_radius;
    logic signed [POS_W-1:0] r_center_x, r_center_y, r_center_z;
    logic                    r_busy;
    logic [LATENCY-1:0]      r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg_count <= RST_SEGMENT_COUNT;
            r_radius    <= RST_RADIUS;
            r_center_x  <= '0;
            r_center_y  <= '0;
            r_center_z  <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SEGMENT_COUNT: r_seg_count <= i_cfg_data[SEG_IN_W-1:0];
                CFG_RADIUS:        r_radius    <= i_cfg_data[RAD_W-1:0];
                CFG_CENTER_X:      r_center_x  <= $signed(i_cfg_data);
                CFG_CENTER_Y:      r_center_y  <= $signed(i_cfg_data);
                CFG_CENTER_Z:      r_center_z  <= $signed(i_cfg_data);
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    logic w_acc;
    assign w_acc = start && !r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r_vld  <= '0;
        end else begin
            r_busy <= 1'b0;
            r_vld  <= {r_vld[LATENCY-2:0], w_acc};
        end
    end

    assign busy    = r_busy;
    assign o_valid = r_vld[LATENCY-1];

    // input stage: clamp and build dividends
    logic [SEG_W-1:0]  w_segs, w_seg;
    logic [RING_W-1:0] w_rings, w_ring;

    always_comb begin
        if (int'(r_seg_count) < MIN_SEGMENTS) begin
            w_segs = SEG_W'(MIN_SEGMENTS);
        end else if (int'(r_seg_count) > MAX_SEGMENTS) begin
            w_segs = SEG_W'(MAX_SEGMENTS);
        end else begin
            w_segs = SEG_W'(r_seg_count);
        end
    end

    assign w_rings = RING_W'(w_segs >> 1);
    assign w_seg   = (int'(i_item.segment) > int'(w_segs)) ? w_segs
                                                           : SEG_W'(i_item.segment);
    assign w_ring  = (int'(i_item.ring) > int'(w_rings)) ? w_rings
                                                         : RING_W'(i_item.ring);

    logic [NW-1:0]    r_dh, r_dv, r_du, r_dt;
    logic [SEG_W-1:0] r_segs, r_rings;

    always_ff @(posedge i_clk) begin
        r_dh    <= (NW'(w_seg) << ANGLE_BITS) + NW'(w_segs >> 1);
        r_dv    <= (NW'(w_ring) << (ANGLE_BITS - 1)) + NW'(w_rings >> 1);
        r_du    <= (NW'(w_seg) << TEX_FRAC) + NW'(w_segs >> 1);
        r_dt    <= (NW'(w_ring) << TEX_FRAC) + NW'(w_rings >> 1);
        r_segs  <= w_segs;
        r_rings <= SEG_W'(w_rings);
    end

    logic [QB-1:0] w_qh, w_qv, w_qu, w_qt;

    sphv_div #(.NW(NW), .DW(SEG_W), .QB(QB)) u_div_h (
        .i_clk(i_clk), .i_dividend(r_dh), .i_divisor(r_segs), .o_quot(w_qh));
    sphv_div #(.NW(NW), .DW(SEG_W), .QB(QB)) u_div_v (
        .i_clk(i_clk), .i_dividend(r_dv), .i_divisor(r_rings), .o_quot(w_qv));
    sphv_div #(.NW(NW), .DW(SEG_W), .QB(QB)) u_div_u (
        .i_clk(i_clk), .i_dividend(r_du), .i_divisor(r_segs), .o_quot(w_qu));
    sphv_div #(.NW(NW), .DW(SEG_W), .QB(QB)) u_div_t (
        .i_clk(i_clk), .i_dividend(r_dt), .i_divisor(r_rings), .o_quot(w_qt));

    t_trig_out w_th, w_tv;

    // phase wraps at one full turn
    sphv_trig #(.ANGLE_BITS(ANGLE_BITS)) u_trig_h (
        .i_clk(i_clk), .i_phase(w_qh[ANGLE_BITS-1:0]), .o_trig(w_th));
    sphv_trig #(.ANGLE_BITS(ANGLE_BITS)) u_trig_v (
        .i_clk(i_clk), .i_phase(w_qv[ANGLE_BITS-1:0]), .o_trig(w_tv));

    logic [TEX_W-1:0] r_tu_d [TEX_DLY];
    logic [TEX_W-1:0] r_tv_d [TEX_DLY];

    always_ff @(posedge i_clk) begin
        r_tu_d[0] <= w_qu[TEX_W-1:0];
        r_tv_d[0] <= TEX_ONE - w_qt[TEX_W-1:0];
        for (int i = 1; i < TEX_DLY; i++) begin
            r_tu_d[i] <= r_tu_d[i-1];
            r_tv_d[i] <= r_tv_d[i-1];
        end
    end

    // direction, scale, offset
    logic [Q_W-1:0]          r_dxm, r_dym, r_dzm;
    logic                    r_dxn, r_dyn, r_dzn;
    logic [POS_W-1:0]        r_offx, r_offy, r_offz;
    logic                    r_sx, r_sy, r_sz;
    logic signed [NRM_W-1:0] r_nx, r_ny, r_nz;
    t_out_word               r_result;

    always_ff @(posedge i_clk) begin
        r_dxm <= mulq(w_th.cos_mag, w_tv.sin_mag);
        r_dzm <= mulq(w_th.sin_mag, w_tv.sin_mag);
        r_dym <= w_tv.cos_mag;
        r_dxn <= w_th.cos_neg ^ w_tv.sin_neg;
        r_dyn <= !w_tv.cos_neg;
        r_dzn <= w_th.sin_neg ^ w_tv.sin_neg;

        r_offx <= scale(r_radius, r_dxm);
        r_offy <= scale(r_radius, r_dym);
        r_offz <= scale(r_radius, r_dzm);
        r_sx   <= r_dxn;
        r_sy   <= r_dyn;
        r_sz   <= r_dzn;
        r_nx   <= to_normal(r_dxm, r_dxn);
        r_ny   <= to_normal(r_dym, r_dyn);
        r_nz   <= to_normal(r_dzm, r_dzn);

        r_result.pos_x    <= sat_add(r_center_x, r_offx, r_sx);
        r_result.pos_y    <= sat_add(r_center_y, r_offy, r_sy);
        r_result.pos_z    <= sat_add(r_center_z, r_offz, r_sz);
        r_result.normal_x <= r_nx;
        r_result.normal_y <= r_ny;
        r_result.normal_z <= r_nz;
        r_result.tex_u    <= r_tu_d[TEX_DLY-1];
        r_result.tex_v    <= r_tv_d[TEX_DLY-1];
    end

    assign o_result = r_result;
endmodule

### rtl/core/sphv_chk.sv
// ----------------------------------------------------------------------------
// sphv_chk: port-level checks for the vertex generator
// Fixed latency from accepted word to vertex strobe, and reset behavior.
// ----------------------------------------------------------------------------
module sphv_chk #(
    parameter int LATENCY = 39
) (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_valid
);
    property p_word_gives_vertex;
        @(posedge i_clk) disable iff (!i_rst_n)
            (start && !busy) |-> ##LATENCY o_valid;
    endproperty

    property p_vertex_has_word;
        @(posedge i_clk) disable iff (!i_rst_n)
            o_valid |-> $past(start && !busy, LATENCY);
    endproperty

    property p_reset_flushes;
        @(posedge i_clk) !i_rst_n |=> (busy && !o_valid);
    endproperty

    property p_ready_after_reset;
        @(posedge i_clk) (i_rst_n && $past(i_rst_n)) |-> !busy;
    endproperty

    a_word_gives_vertex: assert property (p_word_gives_vertex)
        else $error("accepted word produced no vertex");
    a_vertex_has_word: assert property (p_vertex_has_word)
        else $error("vertex strobe without accepted word");
    a_reset_flushes: assert property (p_reset_flushes)
        else $error("reset did not flush pipeline");
    a_ready_after_reset: assert property (p_ready_after_reset)
        else $error("busy high outside reset recovery");
endmodule

bind uv_sphere_vertex_generator_top sphv_chk #(.LATENCY(LATENCY)) u_sphv_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_valid (o_valid)
);
